FILE: rtl/core/sgdm_pkg.sv
package sgdm_pkg;

  // Field widths and fixed-point format.
  localparam int IDX_W      = 10;
  localparam int VAL_W      = 32;
  localparam int FACT_W     = 16;
  localparam int FRAC_BITS  = 16;

  // Velocity store depth and address width.
  localparam int DEPTH      = 1024;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Product of an unsigned factor (zero-extended) and a signed value, and the
  // sum of a shifted product and a value.
  localparam int PROD_W     = FACT_W + 1 + VAL_W;
  localparam int SUM_W      = PROD_W + 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = FACT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE       = 2'd0,
    CFG_LEARN_RATE = 2'd1,
    CFG_MOMENTUM   = 2'd2
  } cfg_reg_t;

  localparam logic              OPT_MOMENTUM  = 1'b1;
  localparam logic              MODE_RESET    = 1'b0;
  localparam logic [FACT_W-1:0] LR_RESET      = 16'd655;
  localparam logic [FACT_W-1:0] MOM_RESET     = 16'd58982;

  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] w;
    logic signed [VAL_W-1:0] g;
    logic                    eop;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic [ADDR_W-1:0]       addr;
    logic signed [VAL_W-1:0] w;
    logic signed [VAL_W-1:0] v;
    logic                    sat_v;
    logic                    mom;
  } vel_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] w;
    logic                    sat;
  } out_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic                    clip;
  } sat_t;

  // Clip a wide signed value to the 32-bit signed range.
  function automatic sat_t sat_val(input logic signed [SUM_W-1:0] x);
    sat_t r;
    if (x > SAT_HI) begin
      r.val  = SAT_HI[VAL_W-1:0];
      r.clip = 1'b1;
    end else if (x < SAT_LO) begin
      r.val  = SAT_LO[VAL_W-1:0];
      r.clip = 1'b1;
    end else begin
      r.val  = x[VAL_W-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  // Element index modulo DEPTH, as a restoring reduction by shifted copies of
  // the constant depth. It reduces to a plain bit slice when the depth covers
  // every index.
  function automatic logic [ADDR_W-1:0] vel_addr(input logic [IDX_W-1:0] idx);
    logic [IDX_W:0] r;
    r = {1'b0, idx};
    for (int k = IDX_W; k >= 0; k--) begin
      if ((longint'(DEPTH) << k) <= longint'(r)) begin
        r = r - (IDX_W+1)'(longint'(DEPTH) << k);
      end
    end
    return ADDR_W'(r);
  endfunction

endpackage

FILE: rtl/core/sgdm_in_if.sv
interface sgdm_in_if;
  import sgdm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        element_index;
  logic signed [VAL_W-1:0] weight_in;
  logic signed [VAL_W-1:0] gradient;
  logic                    end_of_pass;

  modport source (output valid, element_index, weight_in, gradient, end_of_pass,
                  input ready);
  modport sink   (input valid, element_index, weight_in, gradient, end_of_pass,
                  output ready);
endinterface

FILE: rtl/core/sgdm_out_if.sv
interface sgdm_out_if;
  import sgdm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        element_index_out;
  logic signed [VAL_W-1:0] weight_out;
  logic                    saturated;

  modport source (output valid, element_index_out, weight_out, saturated,
                  input ready);
  modport sink   (input valid, element_index_out, weight_out, saturated,
                  output ready);
endinterface

FILE: rtl/core/sgdm_ram.sv
module sgdm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the contents before a write at the same edge.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/sgdm_velocity.sv
module sgdm_velocity (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          mode,
  input  logic [sgdm_pkg::FACT_W-1:0]   momentum,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sgdm_pkg::in_item_t            in_item,
  output logic                          vel_valid,
  input  logic                          vel_ready,
  output sgdm_pkg::vel_item_t           vel_item
);
  import sgdm_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic [ADDR_W-1:0]       addr;
    logic signed [VAL_W-1:0] w;
    logic signed [VAL_W-1:0] g;
    logic                    mom;
    logic                    first;
  } s1_item_t;

  logic                    s1_valid_r;
  s1_item_t                s1_r;
  logic                    s2_valid_r;
  vel_item_t               s2_r;
  logic                    first_pass_r;

  logic                    s1_ready;
  logic                    s2_ready;
  logic                    accept;
  logic [ADDR_W-1:0]       rd_addr;
  logic [VAL_W-1:0]        rd_data;
  logic                    ram_we;
  logic                    fwd;
  logic signed [VAL_W-1:0] vel_old;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] shifted;
  logic signed [SUM_W-1:0] sum;
  sat_t                    vs;
  vel_item_t               s2_nxt;

  assign s2_ready = !s2_valid_r || vel_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;
  assign accept   = in_valid && s1_ready;

  // While an item waits in s1 its address is read again every cycle.
  assign rd_addr = accept ? vel_addr(in_item.idx) : s1_r.addr;
  assign ram_we  = s1_valid_r && s2_ready && s1_r.mom;

  sgdm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_vel_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_r.addr),
    .wdata (s2_nxt.v),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // The item just ahead wrote its velocity on the edge that also read ours,
  // so its value is taken from s2 instead of the memory.
  assign fwd     = s2_valid_r && s2_r.mom && (s2_r.addr == s1_r.addr);
  assign vel_old = fwd ? s2_r.v : $signed(rd_data);

  always_comb begin
    prod    = $signed({1'b0, momentum}) * vel_old;
    shifted = prod >>> FRAC_BITS;
    sum     = {shifted[PROD_W-1], shifted} +
              {{(SUM_W-VAL_W){s1_r.g[VAL_W-1]}}, s1_r.g};
    vs      = sat_val(sum);
    s2_nxt.idx  = s1_r.idx;
    s2_nxt.addr = s1_r.addr;
    s2_nxt.w    = s1_r.w;
    s2_nxt.mom  = s1_r.mom;
    if (s1_r.mom && !s1_r.first) begin
      s2_nxt.v     = vs.val;
      s2_nxt.sat_v = vs.clip;
    end else begin
      s2_nxt.v     = s1_r.g;
      s2_nxt.sat_v = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      first_pass_r <= 1'b1;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (accept && (mode == OPT_MOMENTUM) && in_item.eop) begin
        first_pass_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.idx   <= in_item.idx;
      s1_r.addr  <= vel_addr(in_item.idx);
      s1_r.w     <= in_item.w;
      s1_r.g     <= in_item.g;
      s1_r.mom   <= (mode == OPT_MOMENTUM);
      s1_r.first <= first_pass_r;
    end
    if (s2_ready && s1_valid_r) begin
      s2_r <= s2_nxt;
    end
  end

  assign vel_valid = s2_valid_r;
  assign vel_item  = s2_r;

  a_first_pass_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !first_pass_r |=> !first_pass_r)
    else $error("first-pass flag was set again without reset");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted beat did not reach s1");

  a_write_moves_item: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> s2_valid_r && s2_r.mom && (s2_r.addr == $past(s1_r.addr)))
    else $error("velocity write without matching s2 item");
endmodule

FILE: rtl/core/sgdm_weight.sv
module sgdm_weight (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sgdm_pkg::FACT_W-1:0]   learn_rate,
  input  logic                          vel_valid,
  output logic                          vel_ready,
  input  sgdm_pkg::vel_item_t           vel_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sgdm_pkg::out_item_t           out_item
);
  import sgdm_pkg::*;

  logic                     s3_valid_r;
  logic [IDX_W-1:0]         s3_idx_r;
  logic signed [VAL_W-1:0]  s3_w_r;
  logic signed [PROD_W-1:0] s3_prod_r;
  logic                     s3_sat_r;
  logic                     out_valid_r;
  out_item_t                out_r;

  logic                     s3_ready;
  logic                     o_ready;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] step;
  logic signed [SUM_W-1:0]  diff;
  sat_t                     ws;

  assign o_ready   = !out_valid_r || out_ready;
  assign s3_ready  = !s3_valid_r || o_ready;
  assign vel_ready = s3_ready;

  assign prod_nxt = $signed({1'b0, learn_rate}) * vel_item.v;

  always_comb begin
    step = s3_prod_r >>> FRAC_BITS;
    diff = {{(SUM_W-VAL_W){s3_w_r[VAL_W-1]}}, s3_w_r} - {step[PROD_W-1], step};
    ws   = sat_val(diff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_valid_r <= vel_valid;
      end
      if (o_ready) begin
        out_valid_r <= s3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && vel_valid) begin
      s3_idx_r  <= vel_item.idx;
      s3_w_r    <= vel_item.w;
      s3_prod_r <= prod_nxt;
      s3_sat_r  <= vel_item.sat_v;
    end
    if (o_ready && s3_valid_r) begin
      out_r.idx <= s3_idx_r;
      out_r.w   <= ws.val;
      out_r.sat <= s3_sat_r || ws.clip;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_s3_fill: assert property (@(posedge clk) disable iff (!rst_n)
    vel_valid && s3_ready |=> s3_valid_r)
    else $error("velocity beat lost before s3");

  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r && o_ready |=> out_valid_r && (out_r.idx == $past(s3_idx_r)))
    else $error("s3 item did not reach the output register");
endmodule

FILE: rtl/core/sgd_momentum_weight_update.sv
// SGD weight-update engine with optional momentum. Every beat on the input
// channel carries one parameter element (index, Q16.16 weight, Q16.16
// gradient, end-of-pass mark) and yields exactly one result beat with the
// echoed index, the updated weight and a saturation flag, in input order.
// The engine takes one beat per clock cycle without gaps while the output is
// not stalled and returns each result through the s1, s2, s3 and output
// registers; back-pressure on the output holds the pipeline without loss. The
// rate is set by the velocity stage, where the momentum multiply, the add of
// the gradient and the clip form a loop within that stage, closed by a bypass
// from the next stage, so the same index may repeat on back-to-back beats.
// In momentum mode the velocity of each element lives in a 1024-entry
// memory addressed by the index modulo the store depth; an entry must be
// written (during the first pass) before it is read in later passes, since
// the memory is not cleared after reset. Registers (mode, learning rate,
// momentum factor) are written through the cfg port and must only change
// while no beat is in flight. The first-pass flag is set by reset and clears
// after an end-of-pass beat accepted in momentum mode.
module sgd_momentum_weight_update (
  input  logic                             clk,
  input  logic                             rst_n,
  sgdm_in_if.sink                          in_ch,
  sgdm_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [sgdm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sgdm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import sgdm_pkg::*;

  logic              mode_r;
  logic [FACT_W-1:0] learn_rate_r;
  logic [FACT_W-1:0] momentum_r;

  in_item_t          in_item;
  logic              vel_valid;
  logic              vel_ready;
  vel_item_t         vel_item;
  out_item_t         out_item;

  // Configuration registers. Indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_RESET;
      learn_rate_r <= LR_RESET;
      momentum_r   <= MOM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:       mode_r       <= cfg_wdata[0];
        CFG_LEARN_RATE: learn_rate_r <= cfg_wdata;
        CFG_MOMENTUM:   momentum_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_item.idx = in_ch.element_index;
  assign in_item.w   = in_ch.weight_in;
  assign in_item.g   = in_ch.gradient;
  assign in_item.eop = in_ch.end_of_pass;

  // Stages 1 and 2: velocity read, update and write-back.
  sgdm_velocity u_velocity (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .momentum  (momentum_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .vel_valid (vel_valid),
    .vel_ready (vel_ready),
    .vel_item  (vel_item)
  );

  // Stages 3 and 4: learning-rate product, weight subtract and output register.
  sgdm_weight u_weight (
    .clk        (clk),
    .rst_n      (rst_n),
    .learn_rate (learn_rate_r),
    .vel_valid  (vel_valid),
    .vel_ready  (vel_ready),
    .vel_item   (vel_item),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_item   (out_item)
  );

  assign out_ch.element_index_out = out_item.idx;
  assign out_ch.weight_out        = out_item.w;
  assign out_ch.saturated         = out_item.sat;
endmodule

FILE: bench/sgdm_update_checker.sv
module sgdm_update_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  sgdm_in_if                              in_ch,
  sgdm_out_if                             out_ch,
  input  logic                            cfg_we,
  input  logic [sgdm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sgdm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              mismatch_count,
  output int                              updates_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import sgdm_pkg::*;

  localparam longint WMAX = 2147483647;
  localparam longint WMIN = -WMAX - 1;

  // Shadow copy of the engine: registers, first-pass flag and velocities.
  logic                    mode_q;
  logic                    first_pass_q;
  logic [FACT_W-1:0]       rate_q;
  logic [FACT_W-1:0]       decay_q;
  logic signed [VAL_W-1:0] vel_mem [DEPTH];
  out_item_t               expected_updates[$];
  int                      n_fail;

  function automatic longint clip32(input longint x, inout logic hit);
    if (x > WMAX) begin
      hit = 1'b1;
      return WMAX;
    end
    if (x < WMIN) begin
      hit = 1'b1;
      return WMIN;
    end
    return x;
  endfunction

  // Computes the result of one element and advances the velocity state.
  function automatic out_item_t predict_update(input in_item_t it);
    out_item_t         r;
    logic              hit;
    longint            vel;
    longint            prod;
    longint            nw;
    logic [ADDR_W-1:0] a;
    hit = 1'b0;
    vel = it.g;
    a   = ADDR_W'(it.idx % DEPTH);
    if (mode_q == OPT_MOMENTUM) begin
      if (!first_pass_q) begin
        prod = longint'(decay_q) * longint'(vel_mem[a]);
        vel  = clip32((prod >>> FRAC_BITS) + vel, hit);
      end
      vel_mem[a] = VAL_W'(vel);
      if (it.eop) begin
        first_pass_q = 1'b0;
      end
    end
    nw    = clip32(longint'(it.w) - ((longint'(rate_q) * vel) >>> FRAC_BITS), hit);
    r.idx = it.idx;
    r.w   = VAL_W'(nw);
    r.sat = hit;
    return r;
  endfunction

  task automatic check_field(input string what, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      n_fail++;
    end
  endtask

  initial begin
    n_fail = 0;
  end

  always @(posedge clk) begin
    out_item_t want;
    in_item_t  item;
    if (!rst_n) begin
      mode_q       = MODE_RESET;
      rate_q       = LR_RESET;
      decay_q      = MOM_RESET;
      first_pass_q = 1'b1;
      expected_updates.delete();
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MODE:       mode_q  = cfg_wdata[0];
          CFG_LEARN_RATE: rate_q  = cfg_wdata;
          CFG_MOMENTUM:   decay_q = cfg_wdata;
          default:        ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_updates.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual idx %0d w %0d sat %0b",
                   $time, out_ch.element_index_out, out_ch.weight_out, out_ch.saturated);
          n_fail++;
        end else begin
          want = expected_updates.pop_front();
          check_field("element_index_out", want.idx, out_ch.element_index_out);
          check_field("weight_out", want.w, out_ch.weight_out);
          check_field("saturated", want.sat, out_ch.saturated);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        item.idx = in_ch.element_index;
        item.w   = in_ch.weight_in;
        item.g   = in_ch.gradient;
        item.eop = in_ch.end_of_pass;
        expected_updates.push_back(predict_update(item));
      end
    end
    mismatch_count  <= n_fail;
    updates_pending <= expected_updates.size();
  end

endmodule

FILE: bench/sgd_momentum_weight_update_tb.sv
module sgd_momentum_weight_update_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sgdm_pkg::*;

  // Idle draws per beat on both channels run from zero to this many cycles.
  localparam int GAP_MAX        = 4;
  // One long output hold-off, long enough to fill the pipeline and stall input.
  localparam int LONG_HOLD      = 80;
  // Settle time after the last predicted result, before registers are rewritten.
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 42;
  localparam int SMALL_SPAN     = 1 << 20;
  localparam int POOL_RANDOM    = 26;

  localparam logic                    OPT_PLAIN = 1'b0;
  localparam logic signed [VAL_W-1:0] VMAX      = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VMIN      = 32'sh8000_0000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatch_count;
  int                    updates_pending;

  // Shared between the stimulus and the result-side process. idle_on turns
  // random idling on or off on both channels; hold_out requests one long
  // hold-off of the result channel, which the result side clears itself.
  bit                    idle_on = 1'b1;
  bit                    hold_out = 1'b0;

  // Indices whose velocity was written during the first momentum pass. Once
  // that pass is over, momentum beats only address these entries, since the
  // velocity store holds garbage everywhere else.
  logic [IDX_W-1:0]      vel_pool[$];
  logic [IDX_W-1:0]      last_idx = '0;

  sgdm_in_if  in_ch();
  sgdm_out_if out_ch();

  sgd_momentum_weight_update dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  sgdm_update_checker u_update_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .updates_pending (updates_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Values lean on the corners: the two extremes, zero and minus one show up
  // often, small magnitudes keep the velocity recurrence out of saturation,
  // and the rest is spread over the whole 32-bit range.
  function automatic logic signed [VAL_W-1:0] rand_val();
    unique case ($urandom_range(0, 9))
      0:       return VMAX;
      1:       return VMIN;
      2:       return '0;
      3:       return -1;
      4, 5, 6: return int'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN;
      default: return $urandom;
    endcase
  endfunction

  // A quarter of the beats repeat the previous index, so that updates of the
  // same element land back to back and exercise the velocity bypass.
  function automatic logic [IDX_W-1:0] pick_index(input logic momentum);
    if ($urandom_range(0, 3) != 0) begin
      if (momentum == OPT_MOMENTUM) begin
        last_idx = vel_pool[$urandom_range(0, vel_pool.size() - 1)];
      end else begin
        last_idx = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
      end
    end
    return last_idx;
  endfunction

  // Register writes go out on consecutive edges; the enable drops in a step of
  // its own after the last one.
  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= d;
  endtask

  task automatic set_config(input logic mode, input logic [FACT_W-1:0] rate,
                            input logic [FACT_W-1:0] decay);
    write_reg(CFG_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_LEARN_RATE, rate);
    write_reg(CFG_MOMENTUM, decay);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offers one beat after a random gap and returns at the edge that accepts
  // it. Valid stays high on return, so a following beat without a gap is
  // presented with a single assignment in the same step.
  task automatic send_beat(input logic [IDX_W-1:0] idx, input logic signed [VAL_W-1:0] w,
                           input logic signed [VAL_W-1:0] g, input logic eop);
    int gap;
    gap = idle_on ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.element_index <= idx;
    in_ch.weight_in     <= w;
    in_ch.gradient      <= g;
    in_ch.end_of_pass   <= eop;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drops valid, waits for every predicted result to come back and then lets
  // the pipeline settle, so that the registers can be rewritten safely.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (updates_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result side: a random stall before every beat, or the one long hold-off
  // when the stimulus asks for it. Ready then stays high until a beat goes.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_out) begin
        stall    = LONG_HOLD;
        hold_out = 1'b0;
      end else begin
        stall = idle_on ? $urandom_range(0, GAP_MAX) : 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // Watchdog: ends the run if neither channel moves a beat for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("sgd_momentum_weight_update_tb: errors");
    $finish;
  end

  initial begin
    logic              mode;
    logic [FACT_W-1:0] rate;
    logic [FACT_W-1:0] decay;

    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_MODE;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.element_index <= '0;
    in_ch.weight_in     <= '0;
    in_ch.gradient      <= '0;
    in_ch.end_of_pass   <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Plain descent with the register values from reset. Covers zero input,
    // clipping of the weight in both directions, the shift rounding toward
    // minus infinity on a negative product, a repeated index, and an
    // end-of-pass mark that must leave the first-pass flag alone.
    send_beat(10'd0, '0, '0, 1'b0);
    send_beat(10'd1023, VMAX, VMIN, 1'b1);
    send_beat(10'd682, VMIN, VMAX, 1'b0);
    send_beat(10'd341, 32'sh1234_5678, -1, 1'b0);
    send_beat(10'd5, -1, 32'sd1, 1'b0);
    send_beat(10'd5, 32'sh7FFF_0000, -32'sh0001_0000, 1'b1);
    send_beat(10'd512, VMAX, VMAX, 1'b0);
    drain();

    // First momentum pass: velocity takes the gradient as it is. Every index
    // that later momentum beats may address is written here, including both
    // extremes of the index and one element twice in a row. Only the last
    // beat carries the end-of-pass mark.
    set_config(OPT_MOMENTUM, 16'hFFFF, 16'hFFFF);
    vel_pool = '{10'd0, 10'd1023, 10'd1, 10'd1, 10'd1022, 10'd341, 10'd682};
    repeat (POOL_RANDOM) vel_pool.push_back(IDX_W'($urandom_range(0, (1 << IDX_W) - 1)));
    foreach (vel_pool[k]) begin
      send_beat(vel_pool[k], rand_val(),
                (k == 0) ? VMAX : (k == 1) ? VMIN : rand_val(),
                k == vel_pool.size() - 1);
    end
    drain();

    // Second pass at full momentum: the velocity of element 0 clips high and
    // that of element 1023 clips low; element 0 then comes back after element
    // 1023 with a small gradient so that it reads the clipped velocity from the
    // velocity store.
    send_beat(10'd0, '0, VMAX, 1'b0);
    send_beat(10'd1023, '0, VMIN, 1'b0);
    send_beat(10'd0, VMAX, -1, 1'b0);
    send_beat(10'd1, VMIN, VMAX, 1'b1);
    drain();

    // Random phases, each with a fresh setting. Two out of three run with
    // momentum; the extremes of the rate and of the momentum factor each get
    // a phase. Phase 5 holds the result channel off for a long stretch while
    // beats keep coming, and phase 7 runs without idling on either side.
    for (int ph = 0; ph < PHASES; ph++) begin
      mode  = (ph % 3 != 2) ? OPT_MOMENTUM : OPT_PLAIN;
      rate  = (ph == 2) ? 16'h0000 :
              (ph == 1) ? 16'hFFFF :
              ($urandom_range(0, 1) != 0) ? FACT_W'($urandom_range(0, 4095)) :
                                            FACT_W'($urandom_range(0, 65535));
      decay = (ph == 0) ? 16'h0000 :
              (ph == 4) ? 16'hFFFF : FACT_W'($urandom_range(0, 65535));
      set_config(mode, rate, decay);
      idle_on = (ph != 7);
      // A plain phase may leave an index behind that the first pass never
      // wrote, so a repeat at the start of a phase falls back on the pool.
      last_idx = vel_pool[0];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 5 && n == 10) begin
          hold_out = 1'b1;
        end
        send_beat(pick_index(mode), rand_val(), rand_val(), $urandom_range(0, 7) == 0);
      end
      drain();
    end

    if (mismatch_count == 0 && updates_pending == 0) begin
      $display("sgd_momentum_weight_update_tb: clean");
    end else begin
      $display("sgd_momentum_weight_update_tb: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/sgdm_pkg.sv
rtl/core/sgdm_in_if.sv
rtl/core/sgdm_out_if.sv
rtl/core/sgdm_ram.sv
rtl/core/sgdm_velocity.sv
rtl/core/sgdm_weight.sv
rtl/core/sgd_momentum_weight_update.sv
bench/sgdm_update_checker.sv
bench/sgd_momentum_weight_update_tb.sv
